// ===== rtl/fla_pkg.sv =====
// ----------------------------------------------------------------------------
// fla_pkg
// shared types and constants of the free list block allocator
// ----------------------------------------------------------------------------
package fla_pkg;

    localparam int unsigned HEADER_BYTES = 24;
    localparam int unsigned MAX_SEGS     = 64;
    localparam int unsigned ADDR_BITS    = 32;
    localparam int unsigned IDX_W        = $clog2(MAX_SEGS);
    localparam int unsigned CNT_W        = $clog2(MAX_SEGS + 1);
    localparam int unsigned AL_W         = (ADDR_BITS < 32) ? ADDR_BITS : 32;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_NULL     = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    localparam logic [1:0] REG_POLICY    = 2'd0;
    localparam logic [1:0] REG_HEAP_BASE = 2'd1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_REQ,
        S_SCAN_CHK,
        S_DECIDE,
        S_SHIFT_REQ,
        S_SHIFT_WR,
        S_FINAL,
        S_OUT
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic start;
        logic rd_scan;
        logic chk;
        logic decide;
        logic rd_shift;
        logic wr_shift;
        logic finish;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic scan_done;
        logic early_done;
        logic need_shift;
        logic shift_done;
    } t_sts;

endpackage

// ===== rtl/fla_ctrl.sv =====
// ----------------------------------------------------------------------------
// fla_ctrl
// sequencer for table scan, shift and result hand-off
// ----------------------------------------------------------------------------
module fla_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_fire,
    input  logic              i_out_fire,
    input  fla_pkg::t_sts     i_sts,
    output fla_pkg::t_cmd     o_cmd,
    output logic              o_in_ready,
    output logic              o_out_valid
);

    fla_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fla_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            fla_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_fire) begin
                    o_cmd.start = 1'b1;
                    n_state = fla_pkg::S_SCAN_REQ;
                end
            end
            fla_pkg::S_SCAN_REQ: begin
                if (i_sts.scan_done || i_sts.early_done) begin
                    n_state = fla_pkg::S_DECIDE;
                end else begin
                    o_cmd.rd_scan = 1'b1;
                    n_state = fla_pkg::S_SCAN_CHK;
                end
            end
            fla_pkg::S_SCAN_CHK: begin
                o_cmd.chk = 1'b1;
                n_state = fla_pkg::S_SCAN_REQ;
            end
            fla_pkg::S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = fla_pkg::S_SHIFT_REQ;
            end
            fla_pkg::S_SHIFT_REQ: begin
                if (!i_sts.need_shift || i_sts.shift_done) begin
                    n_state = fla_pkg::S_FINAL;
                end else begin
                    o_cmd.rd_shift = 1'b1;
                    n_state = fla_pkg::S_SHIFT_WR;
                end
            end
            fla_pkg::S_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
                n_state = fla_pkg::S_SHIFT_REQ;
            end
            fla_pkg::S_FINAL: begin
                o_cmd.finish = 1'b1;
                n_state = fla_pkg::S_OUT;
            end
            fla_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_fire) begin
                    n_state = fla_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fla_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/fla_dp.sv =====
// ----------------------------------------------------------------------------
// fla_dp
// segment table, scan registers, shift pointer and result registers
// ----------------------------------------------------------------------------
module fla_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fla_pkg::t_cmd i_cmd,
    input  logic          i_op,
    input  logic [31:0]   i_block_size,
    input  logic [31:0]   i_address,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    output fla_pkg::t_sts o_sts,
    output logic [31:0]   o_block_address,
    output logic [31:0]   o_granted_size,
    output logic [2:0]    o_status,
    output logic [31:0]   o_heap_size,
    output logic [31:0]   o_free_space
);

    localparam int unsigned IW = fla_pkg::IDX_W;
    localparam int unsigned CW = fla_pkg::CNT_W;
    localparam logic [32:0] HDR = 33'(fla_pkg::HEADER_BYTES);

    // table update kinds
    localparam logic [1:0] K_NONE   = 2'd0;
    localparam logic [1:0] K_WRITE  = 2'd1;
    localparam logic [1:0] K_REMOVE = 2'd2;
    localparam logic [1:0] K_INSERT = 2'd3;

    // segment table memory: {start, bytes}
    logic [63:0] r_mem [fla_pkg::MAX_SEGS];
    logic [63:0] r_rd;

    logic        r_policy;
    logic [31:0] r_heap_base;
    logic [CW-1:0] r_count;
    logic [31:0] r_heap_bytes, r_used;

    logic        r_op;
    logic [31:0] r_size, r_hdr;
    logic [CW-1:0] r_pos;     // scan pointer
    logic [IW-1:0] w_rd_addr;
    logic        r_found, r_stop;
    logic [IW-1:0] r_pick;
    logic [31:0] r_pick_start, r_pick_bytes;
    logic [31:0] r_prev_start, r_prev_bytes;
    logic [31:0] r_nx_start, r_nx_bytes;
    logic        r_nx_valid;

    // decision results
    logic [2:0]  r_status;
    logic [31:0] r_addr_out, r_grant;
    logic [1:0]  r_kind;        // none, write, remove or insert at r_tgt
    logic [IW-1:0] r_tgt;
    logic [63:0] r_tgt_val;
    logic [CW-1:0] r_sp;        // shift pointer

    wire [IW-1:0] w_pos_idx = r_pos[IW-1:0];
    wire w_end = (r_pos >= r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy    <= 1'b0;
            r_heap_base <= 32'd4096;
        end else if (i_cfg_we) begin
            if (i_cfg_index == fla_pkg::REG_POLICY) r_policy <= i_cfg_data[0];
            else if (i_cfg_index == fla_pkg::REG_HEAP_BASE) r_heap_base <= i_cfg_data;
        end
    end

    // memory port: read at w_rd_addr, single write
    logic          w_we;
    logic [IW-1:0] w_wa;
    logic [63:0]   w_wd;
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        if (i_cmd.rd_scan || i_cmd.rd_shift) r_rd <= r_mem[w_rd_addr];
    end

    always_comb begin
        w_rd_addr = w_pos_idx;
        if (i_cmd.rd_shift) begin
            // remove reads the entry above, insert reads the entry below
            if (r_kind == K_REMOVE) w_rd_addr = IW'(r_sp + 1'b1);
            else                    w_rd_addr = IW'(r_sp - 1'b1);
        end
    end

    // write on shift step or final single write
    // a free that merges both sides removes the upper entry and rewrites the lower
    always_comb begin
        w_we = 1'b0;
        w_wa = r_sp[IW-1:0];
        w_wd = r_rd;
        if (i_cmd.wr_shift) begin
            w_we = 1'b1;
        end else if (i_cmd.finish && r_status == fla_pkg::ST_OK &&
                     (r_kind == K_WRITE || r_kind == K_INSERT ||
                      (r_kind == K_REMOVE && r_op == fla_pkg::OP_FREE))) begin
            w_we = 1'b1;
            w_wa = r_tgt;
            w_wd = r_tgt_val;
        end
    end

    // decision logic
    logic [2:0]  d_status;
    logic [31:0] d_addr, d_grant;
    logic [1:0]  d_kind;
    logic [IW-1:0] d_tgt;
    logic [63:0] d_val;
    logic [32:0] d_diff;
    logic [33:0] d_hb_total;
    logic [32:0] d_top;
    logic [33:0] d_lim_chk;
    logic [32:0] d_end;
    logic        d_mnext, d_mprev;
    logic [33:0] d_bytes;
    always_comb begin
        d_status = fla_pkg::ST_OK;
        d_addr = '0; d_grant = '0; d_kind = K_NONE; d_tgt = r_pick; d_val = '0;
        d_diff = {1'b0, r_pick_bytes} - {1'b0, r_size};
        d_top = {1'b0, r_heap_base} + {1'b0, r_heap_bytes};
        d_hb_total = {2'b0, r_heap_bytes} + {2'b0, r_size} + {1'b0, HDR};
        d_lim_chk = {1'b0, d_top} + {2'b0, r_size} + {1'b0, HDR};
        d_end = {1'b0, r_hdr} + HDR + {1'b0, r_size};
        d_mnext = r_nx_valid && ({1'b0, r_nx_start} == d_end);
        d_mprev = (r_pos != '0) &&
                  ({1'b0, r_prev_start} + {1'b0, r_prev_bytes} + HDR == {1'b0, r_hdr});
        d_bytes = {2'b0, r_size};
        if (r_op == fla_pkg::OP_ALLOC) begin
            if (r_size == '0) begin
                d_status = fla_pkg::ST_ZERO;
            end else if (r_found) begin
                d_addr = r_pick_start + 32'(fla_pkg::HEADER_BYTES);
                if (d_diff <= HDR) begin
                    d_grant = r_pick_bytes;
                    d_kind  = K_REMOVE;
                end else begin
                    d_grant = r_size;
                    d_kind  = K_WRITE;
                    d_val   = {r_pick_start + r_size + 32'(fla_pkg::HEADER_BYTES),
                               32'(d_diff - HDR)};
                end
            end else if (d_hb_total > 34'h0_FFFF_FFFF ||
                         d_lim_chk > (34'd1 << fla_pkg::AL_W)) begin
                d_status = fla_pkg::ST_OVERFLOW;
            end else begin
                d_addr  = 32'(d_top + HDR);
                d_grant = r_size;
            end
        end else begin
            if (r_size == '0) d_status = fla_pkg::ST_ZERO;
            else if (!d_mnext && !d_mprev && r_count >= CW'(fla_pkg::MAX_SEGS))
                d_status = fla_pkg::ST_FULL;
            if (d_mnext) d_bytes = d_bytes + {2'b0, r_nx_bytes} + {1'b0, HDR};
            if (d_mprev) begin
                d_bytes = d_bytes + {2'b0, r_prev_bytes} + {1'b0, HDR};
                d_tgt = IW'(r_pos - 1'b1);
                d_val = {r_prev_start, d_bytes[31:0]};
                d_kind = d_mnext ? K_REMOVE : K_WRITE;
            end else begin
                d_tgt = w_pos_idx;
                d_val = {r_hdr, d_bytes[31:0]};
                d_kind = d_mnext ? K_WRITE : K_INSERT;
            end
        end
    end

    logic r_null;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0; r_heap_bytes <= '0; r_used <= '0;
            r_status <= fla_pkg::ST_OK; r_kind <= K_NONE;
        end else begin
            if (i_cmd.start) begin
                r_op <= i_op; r_size <= i_block_size;
                r_hdr <= i_address - 32'(fla_pkg::HEADER_BYTES);
                r_null <= i_address < 32'(fla_pkg::HEADER_BYTES);
                r_pos <= '0; r_found <= 1'b0; r_stop <= 1'b0;
                r_nx_valid <= 1'b0;
            end
            if (i_cmd.chk) begin
                if (r_op == fla_pkg::OP_ALLOC) begin
                    if (r_rd[31:0] == r_size) begin
                        r_pick <= w_pos_idx; r_found <= 1'b1; r_stop <= 1'b1;
                        r_pick_start <= r_rd[63:32]; r_pick_bytes <= r_rd[31:0];
                    end else if (r_rd[31:0] > r_size) begin
                        if (!r_policy || !r_found || r_rd[31:0] < r_pick_bytes) begin
                            r_pick <= w_pos_idx; r_found <= 1'b1;
                            r_pick_start <= r_rd[63:32]; r_pick_bytes <= r_rd[31:0];
                        end
                        if (!r_policy) r_stop <= 1'b1;
                        else r_pos <= r_pos + 1'b1;
                    end else r_pos <= r_pos + 1'b1;
                end else begin
                    if (r_rd[63:32] < r_hdr) begin
                        r_prev_start <= r_rd[63:32]; r_prev_bytes <= r_rd[31:0];
                        r_pos <= r_pos + 1'b1;
                    end else begin
                        r_nx_start <= r_rd[63:32]; r_nx_bytes <= r_rd[31:0];
                        r_nx_valid <= 1'b1; r_stop <= 1'b1;
                    end
                end
            end
            if (i_cmd.decide) begin
                r_status <= (r_op == fla_pkg::OP_FREE && r_null) ? fla_pkg::ST_NULL
                                                                : d_status;
                r_addr_out <= d_addr; r_grant <= d_grant;
                r_kind <= d_kind; r_tgt <= d_tgt; r_tgt_val <= d_val;
                // remove: tgt up (free: pos); insert: count down; else no shift
                if (r_op == fla_pkg::OP_FREE && d_mnext) r_sp <= r_pos;
                else if (d_kind == K_REMOVE) r_sp <= CW'(d_tgt);
                else r_sp <= r_count;
            end
            if (i_cmd.wr_shift) begin
                if (r_kind == K_REMOVE) r_sp <= r_sp + 1'b1;
                else r_sp <= r_sp - 1'b1;
            end
            if (i_cmd.finish && r_status == fla_pkg::ST_OK) begin
                if (r_kind == K_REMOVE) r_count <= r_count - 1'b1;
                else if (r_kind == K_INSERT) r_count <= r_count + 1'b1;
                if (r_op == fla_pkg::OP_ALLOC) begin
                    if (!r_found) r_heap_bytes <= r_heap_bytes + r_size +
                                                  32'(fla_pkg::HEADER_BYTES);
                    r_used <= r_used + r_grant + 32'(fla_pkg::HEADER_BYTES);
                end else begin
                    r_used <= r_used - r_size - 32'(fla_pkg::HEADER_BYTES);
                end
            end
        end
    end

    // removal shifts r_sp..count-2 down, insertion shifts count..tgt+1 up
    logic w_ok;
    assign w_ok = (r_status == fla_pkg::ST_OK);
    assign o_sts.scan_done  = w_end;
    assign o_sts.early_done = r_stop;
    assign o_sts.need_shift = w_ok && (r_kind == K_REMOVE || r_kind == K_INSERT);
    assign o_sts.shift_done = (r_kind == K_REMOVE) ? (r_sp + 1'b1 >= r_count)
                                                   : (r_sp <= CW'(r_tgt));

    assign o_block_address = w_ok ? r_addr_out : '0;
    assign o_granted_size  = w_ok ? r_grant : '0;
    assign o_status        = r_status;
    assign o_heap_size     = r_heap_bytes;
    assign o_free_space    = r_heap_bytes - r_used;

endmodule

// ===== rtl/free_list_block_allocator.sv =====
// ----------------------------------------------------------------------------
// free_list_block_allocator
// heap allocator over an address-ordered free segment table
// ----------------------------------------------------------------------------
// One request at a time. A request scans the free table one entry at a time
// (one memory read port: read, then check), then on insert or removal shifts
// entries one at a time (read, then write).
// Result holds until taken; the next request is accepted after that transfer.
module free_list_block_allocator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // block_size, address
    input  logic         s_axis_tuser,   // op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,   // block_address, granted_size, status,
                                         // heap_size, free_space, zero pad
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    fla_pkg::t_cmd w_cmd;
    fla_pkg::t_sts w_sts;
    logic [31:0] w_ba, w_gs, w_hs, w_fs;
    logic [2:0]  w_st;

    // control sequencer
    fla_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_fire  (s_axis_tvalid && s_axis_tready),
        .i_out_fire (m_axis_tvalid && m_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid)
    );

    // table and arithmetic
    fla_dp u_dp (
        .i_clk, .i_rst_n,
        .i_cmd          (w_cmd),
        .i_op           (s_axis_tuser),
        .i_block_size   (s_axis_tdata[31:0]),
        .i_address      (s_axis_tdata[63:32]),
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_sts          (w_sts),
        .o_block_address(w_ba),
        .o_granted_size (w_gs),
        .o_status       (w_st),
        .o_heap_size    (w_hs),
        .o_free_space   (w_fs)
    );

    assign m_axis_tdata = {5'b0, w_fs, w_hs, w_st, w_gs, w_ba};

endmodule

// ===== rtl/fla_checker.sv =====
// ----------------------------------------------------------------------------
// fla_checker
// port level checks of the allocator
// ----------------------------------------------------------------------------
module fla_port_checks (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [135:0] m_axis_tdata
);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[66:64] != fla_pkg::ST_OK |->
        m_axis_tdata[63:0] == '0) else $error("error result carries address");

    a_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |=> s_axis_tready)
        else $error("not ready after result transfer");

endmodule

bind free_list_block_allocator fla_port_checks u_fla_port_checks (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
